>>> rtl/core/sed_pkg.sv
// Shared types and sizes for the spring-damper edge force block.
// Used by the front end, the item queue, the back end and the top level.
package sed_pkg;

	localparam int SQ_STEPS  = 33;               // root bits of a 66 bit radicand
	localparam int RAD_W     = 2 * SQ_STEPS;
	localparam int DIV_STEPS = 31;               // quotient bits of a Q1.30 direction magnitude
	localparam int Q_DEPTH   = 4;                // power of two, pointers wrap freely
	localparam int Q_AW      = $clog2(Q_DEPTH);

	// One classified edge as the back end sees it
	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dvx;
		logic signed [32:0] dvy;
		logic [30:0]        rest;
		logic [30:0]        stiff;
		logic [30:0]        damp;
		logic               zero;    // coincident endpoints
	} sed_item_t;

	typedef struct packed {
		sed_item_t   item;
		logic [63:0] sqx;
		logic [63:0] sqy;
	} sed_work_t;

	typedef struct packed {
		logic full;
		logic avail;
	} sed_q_stat_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [32:0] root;
	} sed_sqrt_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] num;
		logic [30:0] quo;
	} sed_div_t;

endpackage

>>> rtl/core/sed_in_if.sv
// Edge input channel: valid/ready handshake plus the edge fields.
// No dependencies.
interface sed_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_a_x;
	logic signed [31:0] pos_a_y;
	logic signed [31:0] pos_b_x;
	logic signed [31:0] pos_b_y;
	logic signed [31:0] vel_a_x;
	logic signed [31:0] vel_a_y;
	logic signed [31:0] vel_b_x;
	logic signed [31:0] vel_b_y;
	logic [30:0]        rest_length;
	logic [30:0]        stiffness;
	logic [30:0]        damping;

	modport source (
		output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
		output vel_a_x, vel_a_y, vel_b_x, vel_b_y, rest_length, stiffness, damping,
		input  ready
	);
	modport sink (
		input  valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
		input  vel_a_x, vel_a_y, vel_b_x, vel_b_y, rest_length, stiffness, damping,
		output ready
	);
endinterface

>>> rtl/core/sed_out_if.sv
// Force result channel: valid/ready handshake plus force and length.
// No dependencies.
interface sed_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic [30:0]        edge_length;

	modport source (output valid, force_x, force_y, edge_length, input ready);
	modport sink (input valid, force_x, force_y, edge_length, output ready);
endinterface

>>> rtl/core/sed_front.sv
// Front end: accepts edges, forms differences, squares and the coincidence flag.
// Depends on sed_pkg and sed_in_if.
module sed_front import sed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sed_in_if.sink      edge_ch,
	input  sed_q_stat_t q_stat,
	output logic        push,
	output sed_work_t   push_data
);

	logic               v_s1, v_s2, adv;
	logic signed [32:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [30:0]        rest_s1, stiff_s1, damp_s1;
	sed_work_t          work_s2;
	logic [32:0]        negx, negy;
	logic [31:0]        magx, magy;

	// hold both stages while the queue is full and the second stage holds an item
	assign adv          = !v_s2 || !q_stat.full;
	assign edge_ch.ready = adv;
	assign push         = v_s2 && !q_stat.full;
	assign push_data    = work_s2;

	always_comb begin
		negx = -dx_s1;
		negy = -dy_s1;
		magx = dx_s1[32] ? negx[31:0] : dx_s1[31:0];
		magy = dy_s1[32] ? negy[31:0] : dy_s1[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= edge_ch.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1    <= $signed({edge_ch.pos_b_x[31], edge_ch.pos_b_x})
			          - $signed({edge_ch.pos_a_x[31], edge_ch.pos_a_x});
			dy_s1    <= $signed({edge_ch.pos_b_y[31], edge_ch.pos_b_y})
			          - $signed({edge_ch.pos_a_y[31], edge_ch.pos_a_y});
			dvx_s1   <= $signed({edge_ch.vel_b_x[31], edge_ch.vel_b_x})
			          - $signed({edge_ch.vel_a_x[31], edge_ch.vel_a_x});
			dvy_s1   <= $signed({edge_ch.vel_b_y[31], edge_ch.vel_b_y})
			          - $signed({edge_ch.vel_a_y[31], edge_ch.vel_a_y});
			rest_s1  <= edge_ch.rest_length;
			stiff_s1 <= edge_ch.stiffness;
			damp_s1  <= edge_ch.damping;

			work_s2.item.dx    <= dx_s1;
			work_s2.item.dy    <= dy_s1;
			work_s2.item.dvx   <= dvx_s1;
			work_s2.item.dvy   <= dvy_s1;
			work_s2.item.rest  <= rest_s1;
			work_s2.item.stiff <= stiff_s1;
			work_s2.item.damp  <= damp_s1;
			work_s2.item.zero  <= (dx_s1 == '0) && (dy_s1 == '0);
			work_s2.sqx        <= 64'(magx) * 64'(magx);
			work_s2.sqy        <= 64'(magy) * 64'(magy);
		end
	end

endmodule

>>> rtl/core/sed_queue.sv
// Short item queue between front end and back end.
// Depends on sed_pkg.
module sed_queue import sed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sed_work_t   push_data,
	input  logic        pop,
	output sed_work_t   head,
	output sed_q_stat_t q_stat
);

	sed_work_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign q_stat.avail = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

>>> rtl/core/sed_back.sv
// Back end: pipelined square root, direction divide, damper and spring terms,
// force scaling with saturation, and the output register. Depends on sed_pkg, sed_out_if.
module sed_back import sed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sed_work_t   head,
	input  sed_q_stat_t q_stat,
	output logic        pop,
	sed_out_if.source   force_ch
);

	function automatic sed_sqrt_t sqrt_step(sed_sqrt_t st, logic [1:0] pair);
		logic [35:0] acc;
		logic [35:0] trial;
		sed_sqrt_t   r;
		acc   = {st.rem[33:0], pair};
		trial = {1'b0, st.root, 2'b01};
		if (acc >= trial) begin
			r.rem  = acc - trial;
			r.root = {st.root[31:0], 1'b1};
		end else begin
			r.rem  = acc;
			r.root = {st.root[31:0], 1'b0};
		end
		return r;
	endfunction

	function automatic sed_div_t div_init(logic signed [32:0] d);
		logic [32:0] neg;
		logic [31:0] mag;
		sed_div_t    r;
		neg   = -d;
		mag   = d[32] ? neg[31:0] : d[31:0];
		r.rem = {3'b000, mag[31:1]};
		r.num = mag;
		r.quo = '0;
		return r;
	endfunction

	function automatic sed_div_t div_step(sed_div_t st, logic [32:0] den, logic nbit);
		logic [33:0] acc;
		sed_div_t    r;
		acc   = {st.rem[32:0], nbit};
		r.num = st.num;
		if (acc >= {1'b0, den}) begin
			r.rem = acc - {1'b0, den};
			r.quo = {st.quo[29:0], 1'b1};
		end else begin
			r.rem = acc;
			r.quo = {st.quo[29:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [31:0] sat32(logic [50:0] p, logic neg);
		logic [50:0] np;
		np = -p;
		if (neg)
			return (p > 51'h8000_0000) ? 32'h8000_0000 : np[31:0];
		return (p > 51'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
	endfunction

	logic en;
	logic ov_q;

	// freeze the whole back end while a result waits
	assign en  = !ov_q || force_ch.ready;
	assign pop = en && q_stat.avail;

	// square root section
	logic [SQ_STEPS:0] sqv_s;
	sed_item_t         sq_it_s [SQ_STEPS+1];
	logic [RAD_W-1:0]  rad_s   [SQ_STEPS+1];
	sed_sqrt_t         sq_s    [SQ_STEPS+1];

	// divide section
	logic [DIV_STEPS:0] dvv_s;
	sed_item_t          dv_it_s  [DIV_STEPS+1];
	logic [32:0]        dv_len_s [DIV_STEPS+1];
	sed_div_t           dv_x_s   [DIV_STEPS+1];
	sed_div_t           dv_y_s   [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s <= '0;
			dvv_s <= '0;
		end else if (en) begin
			sqv_s <= {sqv_s[SQ_STEPS-1:0], q_stat.avail};
			dvv_s <= {dvv_s[DIV_STEPS-1:0], sqv_s[SQ_STEPS]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_it_s[0] <= head.item;
			rad_s[0]   <= {2'b00, head.sqx} + {2'b00, head.sqy};
			sq_s[0]    <= '0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_it_s[k+1] <= sq_it_s[k];
				rad_s[k+1]   <= rad_s[k];
				sq_s[k+1]    <= sqrt_step(sq_s[k], rad_s[k][2*(SQ_STEPS-1-k) +: 2]);
			end

			dv_it_s[0]  <= sq_it_s[SQ_STEPS];
			dv_len_s[0] <= sq_s[SQ_STEPS].root;
			dv_x_s[0]   <= div_init(sq_it_s[SQ_STEPS].dx);
			dv_y_s[0]   <= div_init(sq_it_s[SQ_STEPS].dy);
			// only the first step brings in a numerator bit; the rest are zero
			for (int k = 0; k < DIV_STEPS; k++) begin
				dv_it_s[k+1]  <= dv_it_s[k];
				dv_len_s[k+1] <= dv_len_s[k];
				dv_x_s[k+1]   <= div_step(dv_x_s[k], dv_len_s[k],
				                          (k == 0) ? dv_x_s[k].num[0] : 1'b0);
				dv_y_s[k+1]   <= div_step(dv_y_s[k], dv_len_s[k],
				                          (k == 0) ? dv_y_s[k].num[0] : 1'b0);
			end
		end
	end

	// force section
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	sed_item_t          it_c, it_s1, it_s2, it_s3, it_s4, it_s5;
	logic [32:0]        len_c, len_s1, len_s2, len_s3, len_s4, len_s5, len_s6;
	logic [30:0]        qx_c, qy_c;
	logic [30:0]        qx_s1, qx_s2, qx_s3, qx_s4, qx_s5;
	logic [30:0]        qy_s1, qy_s2, qy_s3, qy_s4, qy_s5;
	logic signed [31:0] ux_c, uy_c;
	logic signed [64:0] px_c, py_c, px_s1, py_s1;
	logic signed [33:0] ls_c, lsn_c;
	logic [32:0]        lsm_s1;
	logic               spn_s1, spn_s2, spn_s3, spn_s4;
	logic signed [65:0] dsum_s2, dabs_c;
	logic [63:0]        sp_s2, sp_s3, sp_s4;
	logic [32:0]        dmag_s3;
	logic               dneg_s3, dneg_s4;
	logic [63:0]        dm_s4;
	logic [49:0]        td_c, ts_c, s_s5, sabs_c;
	logic [48:0]        a_c;
	logic [49:0]        hx_s6, hy_s6;
	logic [60:0]        lx_s6, ly_s6;
	logic               negx_s6, negy_s6;
	logic [50:0]        pxs_c, pys_c;
	logic signed [31:0] fx_q, fy_q;
	logic [30:0]        len_q;

	always_comb begin
		it_c  = dv_it_s[DIV_STEPS];
		len_c = dv_len_s[DIV_STEPS];
		// coincident endpoints have no direction
		qx_c  = it_c.zero ? '0 : dv_x_s[DIV_STEPS].quo;
		qy_c  = it_c.zero ? '0 : dv_y_s[DIV_STEPS].quo;
		ux_c  = it_c.dx[32] ? -$signed({1'b0, qx_c}) : $signed({1'b0, qx_c});
		uy_c  = it_c.dy[32] ? -$signed({1'b0, qy_c}) : $signed({1'b0, qy_c});
		px_c  = it_c.dvx * ux_c;
		py_c  = it_c.dvy * uy_c;
		ls_c  = $signed({1'b0, len_c}) - $signed({3'b000, it_c.rest});
		lsn_c = -ls_c;

		dabs_c = dsum_s2[65] ? -dsum_s2 : dsum_s2;

		td_c = {2'b00, dm_s4[63:16]};
		ts_c = {2'b00, sp_s4[63:16]};

		sabs_c = -s_s5;
		a_c    = s_s5[49] ? sabs_c[48:0] : s_s5[48:0];

		pxs_c = {1'b0, hx_s6} + {20'b0, lx_s6[60:30]};
		pys_c = {1'b0, hy_s6} + {20'b0, ly_s6[60:30]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			v_s1 <= dvv_s[DIV_STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			ov_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= it_c;
			len_s1 <= len_c;
			qx_s1  <= qx_c;
			qy_s1  <= qy_c;
			px_s1  <= px_c;
			py_s1  <= py_c;
			spn_s1 <= ls_c[33];
			lsm_s1 <= ls_c[33] ? lsn_c[32:0] : ls_c[32:0];

			it_s2   <= it_s1;
			len_s2  <= len_s1;
			qx_s2   <= qx_s1;
			qy_s2   <= qy_s1;
			spn_s2  <= spn_s1;
			dsum_s2 <= px_s1 + py_s1;
			sp_s2   <= 64'(it_s1.stiff) * 64'(lsm_s1);

			// dot magnitude rounds toward zero
			it_s3   <= it_s2;
			len_s3  <= len_s2;
			qx_s3   <= qx_s2;
			qy_s3   <= qy_s2;
			spn_s3  <= spn_s2;
			sp_s3   <= sp_s2;
			dneg_s3 <= dsum_s2[65];
			dmag_s3 <= dabs_c[62:30];

			it_s4   <= it_s3;
			len_s4  <= len_s3;
			qx_s4   <= qx_s3;
			qy_s4   <= qy_s3;
			spn_s4  <= spn_s3;
			sp_s4   <= sp_s3;
			dneg_s4 <= dneg_s3;
			dm_s4   <= 64'(it_s3.damp) * 64'(dmag_s3);

			it_s5  <= it_s4;
			len_s5 <= len_s4;
			qx_s5  <= qx_s4;
			qy_s5  <= qy_s4;
			s_s5   <= (dneg_s4 ? -td_c : td_c) + (spn_s4 ? -ts_c : ts_c);

			len_s6  <= len_s5;
			negx_s6 <= s_s5[49] ^ it_s5.dx[32];
			negy_s6 <= s_s5[49] ^ it_s5.dy[32];
			hx_s6   <= 50'(a_c[48:30]) * 50'(qx_s5);
			hy_s6   <= 50'(a_c[48:30]) * 50'(qy_s5);
			lx_s6   <= 61'(a_c[29:0]) * 61'(qx_s5);
			ly_s6   <= 61'(a_c[29:0]) * 61'(qy_s5);

			fx_q  <= sat32(pxs_c, negx_s6);
			fy_q  <= sat32(pys_c, negy_s6);
			len_q <= (len_s6[32:31] != 2'b00) ? 31'h7FFF_FFFF : len_s6[30:0];
		end
	end

	assign force_ch.valid       = ov_q;
	assign force_ch.force_x     = fx_q;
	assign force_ch.force_y     = fy_q;
	assign force_ch.edge_length = len_q;

endmodule

>>> rtl/core/spring_damper_edge_force.sv
// Spring-damper edge force. Throughput: one edge per cycle while the output is
// not stalled, set by the fully pipelined 33-step square root and 31-step
// direction divider.
// A stalled result holds the back end; the 4-entry queue keeps input open a while.
// Reset clears valid flags, queue pointers and the queue count only; no clearing pass.
module spring_damper_edge_force import sed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sed_in_if.sink    edge_ch,
	sed_out_if.source force_ch
);

	logic        push, pop;
	sed_work_t   push_data, head;
	sed_q_stat_t q_stat;

	sed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_ch   (edge_ch),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	sed_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	sed_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.force_ch (force_ch)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("item pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.avail)
		else $error("item popped from empty queue");

	a_zero_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(force_ch.valid && (force_ch.edge_length == '0))
		|-> (force_ch.force_x == '0) && (force_ch.force_y == '0))
		else $error("zero-length edge with nonzero force");

endmodule

>>> sim/force_checker.sv
`timescale 1ns / 100ps
// Force checker: watches the edge and force channels, predicts each force
// result from the accepted edge and compares. Depends on sed_in_if, sed_out_if.
module force_checker (
	input  logic  clk,
	input  logic  arst_n,
	sed_in_if     edge_ch,
	sed_out_if    force_ch,
	output int    fail_count,
	output int    pending,
	output logic  moved
);
	typedef struct {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic [30:0]        len;
	} force_t;

	force_t expected_forces[$];

	function automatic logic [32:0] root66(logic [65:0] v);
		logic [35:0] rem;
		logic [35:0] trial;
		logic [32:0] root;
		rem = 0;
		root = 0;
		for (int i = 32; i >= 0; i--) begin
			rem = {rem[33:0], v[2*i+1 -: 2]};
			trial = {1'b0, root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[31:0], 1'b1};
			end else begin
				root = {root[31:0], 1'b0};
			end
		end
		return root;
	endfunction

	// trunc(coef * v / 2^16) with the sign of v
	function automatic longint coef_term(longint coef, longint v);
		logic [127:0] m;
		m = (128'(coef) * 128'(v < 0 ? -v : v)) >> 16;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] scale_clamp(longint s, longint u);
		logic signed [127:0] p;
		p = 128'(s) * 128'(u);
		p = p / 128'sd1073741824;
		if (p > 128'sd2147483647) return 32'sh7fffffff;
		if (p < -128'sd2147483648) return 32'sh80000000;
		return p[31:0];
	endfunction

	function automatic force_t edge_force(longint dx, longint dy, longint dvx,
			longint dvy, longint rest, longint stiff, longint damp);
		force_t r;
		logic [65:0] sq;
		longint len, ux, uy, dot, s;
		// squares can exceed the signed 64 bit range, read them unsigned
		sq = 66'($unsigned(dx * dx)) + 66'($unsigned(dy * dy));
		len = longint'(root66(sq));
		ux = 0;
		uy = 0;
		if (len != 0) begin
			ux = (dx * 64'sd1073741824) / len;
			uy = (dy * 64'sd1073741824) / len;
		end
		dot = (dvx * ux + dvy * uy) / 64'sd1073741824;
		s = coef_term(damp, dot) + coef_term(stiff, len - rest);
		r.fx = scale_clamp(s, ux);
		r.fy = scale_clamp(s, uy);
		r.len = len > 64'h7fffffff ? 31'h7fffffff : 31'(len);
		return r;
	endfunction

	assign pending = expected_forces.size();

	always @(posedge clk or negedge arst_n) begin
		force_t e;
		int     errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			moved <= 1'b0;
		end else begin
			moved <= (edge_ch.valid && edge_ch.ready) || (force_ch.valid && force_ch.ready);
			if (edge_ch.valid && edge_ch.ready)
				expected_forces.push_back(edge_force(
					longint'(edge_ch.pos_b_x) - longint'(edge_ch.pos_a_x),
					longint'(edge_ch.pos_b_y) - longint'(edge_ch.pos_a_y),
					longint'(edge_ch.vel_b_x) - longint'(edge_ch.vel_a_x),
					longint'(edge_ch.vel_b_y) - longint'(edge_ch.vel_a_y),
					longint'(edge_ch.rest_length), longint'(edge_ch.stiffness),
					longint'(edge_ch.damping)));
			if (force_ch.valid && force_ch.ready) begin
				if (expected_forces.size() == 0) begin
					$error("force item with no edge waiting");
					errs++;
				end else begin
					e = expected_forces.pop_front();
					if (force_ch.force_x !== e.fx) begin
						$error("force_x expected %0d got %0d", e.fx, force_ch.force_x);
						errs++;
					end
					if (force_ch.force_y !== e.fy) begin
						$error("force_y expected %0d got %0d", e.fy, force_ch.force_y);
						errs++;
					end
					if (force_ch.edge_length !== e.len) begin
						$error("edge_length expected %0d got %0d", e.len,
							force_ch.edge_length);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the edge force test: drives edges with random gaps and result stalls,
// gives the verdict. Depends on the edge force top, its interfaces, force_checker.
module testbench;
	localparam int WATCHDOG = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending;
	logic moved;
	int   idle_cycles = 0;

	sed_in_if  edge_ch();
	sed_out_if force_ch();

	spring_damper_edge_force uut (.clk(clk), .arst_n(arst_n), .edge_ch(edge_ch),
		.force_ch(force_ch));
	force_checker checker_i (.clk(clk), .arst_n(arst_n), .edge_ch(edge_ch),
		.force_ch(force_ch), .fail_count(fail_count), .pending(pending), .moved(moved));

	always #5 clk = ~clk;

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff - $urandom_range(0, 3);
			1: return 32'h80000000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 3) << 16;
			3: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] pick_coef();
		case ($urandom_range(0, 4))
			0: return 31'h7fffffff;
			1: return 31'h0;
			2: return 31'($urandom_range(0, 1 << 20));
			default: return 31'($urandom());
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_edge(logic [31:0] ax, ay, bx, by, vax, vay, vbx, vby,
			logic [30:0] rest, stiff, damp);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap != 0) begin
			edge_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		edge_ch.valid <= 1'b1;
		edge_ch.pos_a_x <= ax;  edge_ch.pos_a_y <= ay;
		edge_ch.pos_b_x <= bx;  edge_ch.pos_b_y <= by;
		edge_ch.vel_a_x <= vax; edge_ch.vel_a_y <= vay;
		edge_ch.vel_b_x <= vbx; edge_ch.vel_b_y <= vby;
		edge_ch.rest_length <= rest; edge_ch.stiffness <= stiff; edge_ch.damping <= damp;
		// ready is stable between edges; it is taken at the next rising edge
		while (!edge_ch.ready) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_edge();
		logic [31:0] ax, ay;
		ax = pick32();
		ay = pick32();
		if ($urandom_range(0, 15) == 0)
			send_edge(ax, ay, ax, ay, pick32(), pick32(), pick32(), pick32(),
				pick_coef(), pick_coef(), pick_coef());
		else
			send_edge(ax, ay, pick32(), pick32(), pick32(), pick32(), pick32(),
				pick32(), pick_coef(), pick_coef(), pick_coef());
	endtask

	// result stalls: ready is dropped at random before each result, then held high until it is taken
	initial begin
		int stall;
		force_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, 6);
			if (stall != 0) begin
				force_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			force_ch.ready <= 1'b1;
			while (!force_ch.valid) @(negedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		idle_cycles <= moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		edge_ch.valid = 1'b0;
		{edge_ch.pos_a_x, edge_ch.pos_a_y, edge_ch.pos_b_x, edge_ch.pos_b_y} = '0;
		{edge_ch.vel_a_x, edge_ch.vel_a_y, edge_ch.vel_b_x, edge_ch.vel_b_y} = '0;
		{edge_ch.rest_length, edge_ch.stiffness, edge_ch.damping} = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		// coincident endpoints
		send_edge('0, '0, '0, '0, 32'h10000, '0, '0, '0, 31'h10000, 31'h7fffffff,
			31'h7fffffff);
		send_edge(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, '1, '1, '1);
		// long edges: saturated length, full range
		send_edge(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			'0, '0, '0, '0, '0, 31'h10000, '0);
		send_edge(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, '1, '1, '1);
		// unit edges, spring only and damper only; then a longer edge with both terms
		send_edge('0, '0, 32'h10000, '0, '0, '0, '0, '0, 31'h8000, 31'h10000, '0);
		send_edge('0, '0, '0, 32'hffff0000, '0, '0, '0, 32'h10000, '0, '0, 31'h10000);
		send_edge('0, '0, 32'h30000, 32'h40000, '0, '0, 32'hfffe0000, 32'h1000,
			31'h20000, 31'h30000, 31'h8000);
		// large force saturates each way
		send_edge('0, '0, 32'h10000000, 32'hf0000000, '0, '0, '0, '0, '0, '1, '1);
		send_edge('0, '0, 32'h1, '0, '0, '0, '0, '0, '1, '1, '0);
		send_edge('0, '0, 32'hffffffff, 32'h1, 32'h7fffffff, '0, 32'h80000000, '0,
			'0, '0, '1);
		for (int i = 0; i < 1340; i++) begin
			send_random_edge();
			if (i == 600) begin
				// drain fully before continuing
				edge_ch.valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
			end
		end
		edge_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

>>> spring_damper_edge_force.f
rtl/core/sed_pkg.sv
rtl/core/sed_in_if.sv
rtl/core/sed_out_if.sv
rtl/core/sed_front.sv
rtl/core/sed_queue.sv
rtl/core/sed_back.sv
rtl/core/spring_damper_edge_force.sv
sim/force_checker.sv
sim/testbench.sv
